// ===== hdl/eat_pkg.sv =====
// Shared types and constants for the coalescing event audit table.
package eat_pkg;

   // Field widths of one event word and one result word.
   localparam int CALL_W   = 10;
   localparam int PID_W    = 22;
   localparam int ARG_W    = 64;
   localparam int HITS_W   = 32;
   localparam int DESC_W   = 31;
   localparam int SLOT_W   = 6;
   localparam int INUSE_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Reset value of the ioctl call number register.
   localparam logic [CALL_W-1:0] IOCTL_CALL_RESET = 10'd16;

   // Saturation value of an entry's hit count.
   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXEMPT_ENABLE = 2'd0,
      CSR_EXEMPT_DESC   = 2'd1,
      CSR_IOCTL_CALL    = 2'd2
   } csr_index_type;

   // What happened to one event.
   typedef enum logic [1:0] {
      OUT_EXEMPT  = 2'd0,
      OUT_MERGED  = 2'd1,
      OUT_NEW     = 2'd2,
      OUT_DROPPED = 2'd3
   } outcome_type;

   // Lookup sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   // Configuration seen by the lookup engine.
   typedef struct packed {
      logic              exempt_enable;
      logic [DESC_W-1:0] exempt_descriptor;
      logic [CALL_W-1:0] ioctl_call_number;
   } cfg_type;

   // One stored table entry: the key, the creating pid and the hit count.
   typedef struct packed {
      logic [CALL_W-1:0] call_number;
      logic [ARG_W-1:0]  arg_a;
      logic [ARG_W-1:0]  arg_b;
      logic [ARG_W-1:0]  arg_c;
      logic [PID_W-1:0]  origin_pid;
      logic [HITS_W-1:0] hits;
   } entry_type;

   // One result word.
   typedef struct packed {
      outcome_type        outcome;
      logic [SLOT_W-1:0]  entry_index;
      logic [HITS_W-1:0]  entry_hits;
      logic [PID_W-1:0]   first_pid;
      logic [INUSE_W-1:0] entries_in_use;
   } rsp_type;

endpackage

// ===== hdl/eat_csr.sv =====
// Configuration registers of the audit table, written over the csr channel.
module eat_csr
   import eat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic              exempt_enable_ff;
   logic [DESC_W-1:0] exempt_desc_ff;
   logic [CALL_W-1:0] ioctl_call_ff;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Each register keeps only its own width of the written word.
   always_ff @(posedge clock) begin
      if (reset) begin
         exempt_enable_ff <= 1'b0;
         exempt_desc_ff   <= '0;
         ioctl_call_ff    <= IOCTL_CALL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXEMPT_ENABLE: exempt_enable_ff <= csr_wdata[0];
            CSR_EXEMPT_DESC:   exempt_desc_ff   <= csr_wdata[DESC_W-1:0];
            CSR_IOCTL_CALL:    ioctl_call_ff    <= csr_wdata[CALL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.exempt_enable     = exempt_enable_ff;
   assign cfg.exempt_descriptor = exempt_desc_ff;
   assign cfg.ioctl_call_number = ioctl_call_ff;

endmodule

// ===== hdl/eat_rsp_reg.sv =====
// Output register that holds one result word until the consumer takes it.
module eat_rsp_reg
   import eat_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_type            push_word,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_outcome,
   output logic [SLOT_W-1:0]  rsp_entry_index,
   output logic [HITS_W-1:0]  rsp_entry_hits,
   output logic [PID_W-1:0]   rsp_first_pid,
   output logic [INUSE_W-1:0] rsp_entries_in_use
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   // The slot can take a new word when empty or when the held word leaves now.
   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = push || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The word itself needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         word_ff <= push_word;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_outcome        = word_ff.outcome;
   assign rsp_entry_index    = word_ff.entry_index;
   assign rsp_entry_hits     = word_ff.entry_hits;
   assign rsp_first_pid      = word_ff.first_pid;
   assign rsp_entries_in_use = word_ff.entries_in_use;

endmodule

// ===== hdl/eat_engine.sv =====
// Lookup engine: entry memory, linear key scan, merge or append, and fill level.
module eat_engine
   import eat_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CALL_W-1:0] req_call_number,
   input  logic [PID_W-1:0]  req_process_id,
   input  logic [ARG_W-1:0]  req_first_arg,
   input  logic [ARG_W-1:0]  req_second_arg,
   input  logic [ARG_W-1:0]  req_third_arg,
   input  logic              out_free,
   output logic              push,
   output rsp_type           push_word
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Sequencer and captured event.
   state_type         state_ff, state_in;
   logic [CALL_W-1:0] call_ff, call_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [ARG_W-1:0]  arg_a_ff, arg_a_in;
   logic [ARG_W-1:0]  arg_b_ff, arg_b_in;
   logic [ARG_W-1:0]  arg_c_ff, arg_c_in;
   logic              exempt_ff, exempt_in;

   // Scan pointers and table fill level.
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   rsp_type           word_ff, word_in;

   // Entry memory ports.
   entry_type         slot_mem_ff [TABLE_DEPTH];
   entry_type         rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   // Helpers.
   logic              accept;
   logic              exempt_now;
   logic              key_hit;
   logic [HITS_W-1:0] hits_next;
   logic [IDX_W-1:0]  slot;
   logic [CNT_W-1:0]  fill_plus;
   logic [IDX_W+SLOT_W-1:0]  slot_ext;
   logic [CNT_W+INUSE_W-1:0] fill_ext;
   logic [CNT_W+INUSE_W-1:0] fill_new_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // An ioctl aimed at the exempt descriptor is not recorded.
   assign exempt_now = cfg.exempt_enable &&
                       (req_call_number == cfg.ioctl_call_number) &&
                       (req_first_arg[31:0] == {1'b0, cfg.exempt_descriptor});

   // Read one entry per cycle below the fill level; compare it in the cycle after the read.
   assign rd_en   = (state_ff == ST_SCAN) && !exempt_ff && (issue_ff < fill_ff);
   assign rd_addr = issue_ff[IDX_W-1:0];

   assign key_hit = cmp_valid_ff &&
                    (rd_data_ff.call_number == call_ff) &&
                    (rd_data_ff.arg_a == arg_a_ff) &&
                    (rd_data_ff.arg_b == arg_b_ff) &&
                    (rd_data_ff.arg_c == arg_c_ff);

   assign hits_next = (rd_data_ff.hits == HITS_MAX) ? HITS_MAX
                                                     : rd_data_ff.hits + 32'd1;

   // The slot reported is the matched entry or the next free one.
   assign slot         = key_hit ? cmp_idx_ff : fill_ff[IDX_W-1:0];
   assign slot_ext     = {{SLOT_W{1'b0}}, slot};
   assign fill_plus    = fill_ff + CNT_W'(1);
   assign fill_ext     = {{INUSE_W{1'b0}}, fill_ff};
   assign fill_new_ext = {{INUSE_W{1'b0}}, fill_plus};

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, memory writes and the result word.
   always_comb begin
      state_in     = state_ff;
      call_in      = call_ff;
      pid_in       = pid_ff;
      arg_a_in     = arg_a_ff;
      arg_b_in     = arg_b_ff;
      arg_c_in     = arg_c_ff;
      exempt_in    = exempt_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      cmp_valid_in = rd_en;
      cmp_idx_in   = rd_addr;
      word_in      = word_ff;
      wr_en        = 1'b0;
      wr_addr      = slot;
      wr_data      = rd_data_ff;
      push         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            cmp_valid_in = 1'b0;
            if (accept) begin
               call_in   = req_call_number;
               pid_in    = req_process_id;
               arg_a_in  = req_first_arg;
               arg_b_in  = req_second_arg;
               arg_c_in  = req_third_arg;
               exempt_in = exempt_now;
               issue_in  = '0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (exempt_ff) begin
               word_in.outcome        = OUT_EXEMPT;
               word_in.entry_index    = '0;
               word_in.entry_hits     = '0;
               word_in.first_pid      = '0;
               word_in.entries_in_use = fill_ext[INUSE_W-1:0];
               state_in               = ST_FINISH;
            end else if (key_hit) begin
               // Merge into the matched entry.
               wr_en                  = 1'b1;
               wr_data.hits           = hits_next;
               word_in.outcome        = OUT_MERGED;
               word_in.entry_index    = slot_ext[SLOT_W-1:0];
               word_in.entry_hits     = hits_next;
               word_in.first_pid      = rd_data_ff.origin_pid;
               word_in.entries_in_use = fill_ext[INUSE_W-1:0];
               state_in               = ST_FINISH;
            end else if (!rd_en) begin
               // Every entry in use has been compared without a match.
               if (fill_ff == DEPTH_CNT) begin
                  word_in.outcome        = OUT_DROPPED;
                  word_in.entry_index    = '0;
                  word_in.entry_hits     = '0;
                  word_in.first_pid      = '0;
                  word_in.entries_in_use = fill_ext[INUSE_W-1:0];
               end else begin
                  wr_en                  = 1'b1;
                  wr_data.call_number    = call_ff;
                  wr_data.arg_a          = arg_a_ff;
                  wr_data.arg_b          = arg_b_ff;
                  wr_data.arg_c          = arg_c_ff;
                  wr_data.origin_pid     = pid_ff;
                  wr_data.hits           = 32'd1;
                  fill_in                = fill_plus;
                  word_in.outcome        = OUT_NEW;
                  word_in.entry_index    = slot_ext[SLOT_W-1:0];
                  word_in.entry_hits     = 32'd1;
                  word_in.first_pid      = pid_ff;
                  word_in.entries_in_use = fill_new_ext[INUSE_W-1:0];
               end
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            cmp_valid_in = 1'b0;
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   // Captured event, compare slot and result word.
   always_ff @(posedge clock) begin
      call_ff    <= call_in;
      pid_ff     <= pid_in;
      arg_a_ff   <= arg_a_in;
      arg_b_ff   <= arg_b_in;
      arg_c_ff   <= arg_c_in;
      exempt_ff  <= exempt_in;
      cmp_idx_ff <= cmp_idx_in;
      word_ff    <= word_in;
   end

   // Entry memory: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign push_word = word_ff;

endmodule

// ===== hdl/coalescing_event_audit_table_top.sv =====
// Top level of the coalescing event audit table.
//
//   Channel  Handshake             Word
//   req      req_valid/req_stall   call number, process id, three argument words
//   rsp      rsp_valid/rsp_stall   outcome, slot, hit count, first pid, entries in use
//   csr      csr_valid/csr_ready   register index and write data
//
// An event occupies the engine until its result is pushed into the output
// register: the scan reads one entry per cycle from the single read port of
// the entry memory, and a match ends the scan early. An exempt event skips it.
// Reset is synchronous and clears the fill level, so the table starts empty;
// entry contents are never cleared. A stalled result waits in the output
// register while the next event is already being looked up.
module coalescing_event_audit_table_top
   import eat_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CALL_W-1:0]     req_call_number,
   input  logic [PID_W-1:0]      req_process_id,
   input  logic [ARG_W-1:0]      req_first_arg,
   input  logic [ARG_W-1:0]      req_second_arg,
   input  logic [ARG_W-1:0]      req_third_arg,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_outcome,
   output logic [SLOT_W-1:0]     rsp_entry_index,
   output logic [HITS_W-1:0]     rsp_entry_hits,
   output logic [PID_W-1:0]      rsp_first_pid,
   output logic [INUSE_W-1:0]    rsp_entries_in_use,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    out_free;
   logic    push;
   rsp_type push_word;

   // Configuration registers.
   eat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Lookup engine with the entry memory.
   eat_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_call_number (req_call_number),
      .req_process_id  (req_process_id),
      .req_first_arg   (req_first_arg),
      .req_second_arg  (req_second_arg),
      .req_third_arg   (req_third_arg),
      .out_free        (out_free),
      .push            (push),
      .push_word       (push_word)
   );

   // Result output register.
   eat_rsp_reg u_rsp (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .push_word          (push_word),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_entry_hits     (rsp_entry_hits),
      .rsp_first_pid      (rsp_first_pid),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

   // The engine only hands over a word when the output register can hold it.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into an occupied output register");

   // An accepted event keeps the engine busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine took no time for an accepted event");

   // Exempt and dropped events report no slot, count or pid.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUT_EXEMPT || rsp_outcome == OUT_DROPPED)) |->
      (rsp_entry_index == '0 && rsp_entry_hits == '0 && rsp_first_pid == '0))
      else $error("exempt or dropped result carries entry data");

   // A new entry starts at one hit and a merged one never reads zero.
   a_hits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUT_NEW || rsp_outcome == OUT_MERGED)) |->
      (rsp_entry_hits != '0 &&
       (rsp_outcome != OUT_NEW || rsp_entry_hits == 32'd1)))
      else $error("hit count out of line with the outcome");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the coalescing event audit table.
module tb
   import eat_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH      = 64;
   localparam int RANDOM_PHASES    = 5;
   localparam int RANDOM_PER_PHASE = 250;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 200;
   localparam int CYCLE_LIMIT      = 800000;
   localparam int REPORT_LIMIT     = 10;

   // Index past the end of the register list; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // One event word as offered on the input channel.
   typedef struct packed {
      logic [CALL_W-1:0] call_number;
      logic [PID_W-1:0]  process_id;
      logic [ARG_W-1:0]  first_arg;
      logic [ARG_W-1:0]  second_arg;
      logic [ARG_W-1:0]  third_arg;
   } audit_event_type;

   // Mirror of the key table and registers; predicts each result word and
   // compares it with what the block returns.
   class audit_table_mirror;
      bit              exempt_on;
      bit [DESC_W-1:0] exempt_desc;
      bit [CALL_W-1:0] ioctl_call;
      bit [CALL_W-1:0] key_call   [TABLE_DEPTH];
      bit [ARG_W-1:0]  key_a      [TABLE_DEPTH];
      bit [ARG_W-1:0]  key_b      [TABLE_DEPTH];
      bit [ARG_W-1:0]  key_c      [TABLE_DEPTH];
      bit [PID_W-1:0]  origin_pid [TABLE_DEPTH];
      bit [HITS_W-1:0] hit_total  [TABLE_DEPTH];
      int              fill;
      rsp_type         awaited_results[$];
      int              outcome_tally[4];
      int              events_seen;
      int              results_checked;
      int              errors;

      function new();
         exempt_on   = 1'b0;
         exempt_desc = '0;
         ioctl_call  = IOCTL_CALL_RESET;
         fill        = 0;
      endfunction

      // Only the register's own width is kept.
      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_EXEMPT_ENABLE: exempt_on   = data[0];
            CSR_EXEMPT_DESC:   exempt_desc = data[DESC_W-1:0];
            CSR_IOCTL_CALL:    ioctl_call  = data[CALL_W-1:0];
            default: ;
         endcase
      endfunction

      // Apply one accepted event to the mirror and queue the result it causes.
      function void record_event(audit_event_type ev);
         rsp_type want;
         int      slot;
         want = '0;
         slot = -1;
         events_seen++;
         if (exempt_on && ev.call_number == ioctl_call &&
             ev.first_arg[31:0] == {1'b0, exempt_desc}) begin
            want.outcome = OUT_EXEMPT;
         end else begin
            // Linear search over the filled part of the table only.
            for (int i = 0; i < fill; i++) begin
               if (key_call[i] == ev.call_number && key_a[i] == ev.first_arg &&
                   key_b[i] == ev.second_arg && key_c[i] == ev.third_arg) begin
                  slot = i;
                  break;
               end
            end
            if (slot >= 0) begin
               // The hit count saturates instead of wrapping.
               if (hit_total[slot] != HITS_MAX)
                  hit_total[slot]++;
               want.outcome     = OUT_MERGED;
               want.entry_index = slot[SLOT_W-1:0];
               want.entry_hits  = hit_total[slot];
               want.first_pid   = origin_pid[slot];
            end else if (fill >= TABLE_DEPTH) begin
               want.outcome = OUT_DROPPED;
            end else begin
               key_call[fill]   = ev.call_number;
               key_a[fill]      = ev.first_arg;
               key_b[fill]      = ev.second_arg;
               key_c[fill]      = ev.third_arg;
               origin_pid[fill] = ev.process_id;
               hit_total[fill]  = 1;
               want.outcome     = OUT_NEW;
               want.entry_index = fill[SLOT_W-1:0];
               want.entry_hits  = 1;
               want.first_pid   = ev.process_id;
               fill++;
            end
         end
         want.entries_in_use = INUSE_W'(fill);
         outcome_tally[want.outcome]++;
         awaited_results.push_back(want);
      endfunction

      // Compare one accepted result word with the oldest prediction.
      function void check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result word: %0d/%0d/%0d/%0d/%0d",
                        got.outcome, got.entry_index, got.entry_hits, got.first_pid,
                        got.entries_in_use);
            return;
         end
         want = awaited_results.pop_front();
         if (got.outcome !== want.outcome || got.entry_index !== want.entry_index ||
             got.entry_hits !== want.entry_hits || got.first_pid !== want.first_pid ||
             got.entries_in_use !== want.entries_in_use) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("result %0d: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                        results_checked, want.outcome, want.entry_index, want.entry_hits,
                        want.first_pid, want.entries_in_use, got.outcome, got.entry_index,
                        got.entry_hits, got.first_pid, got.entries_in_use);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CALL_W-1:0]     req_call_number = '0;
   logic [PID_W-1:0]      req_process_id = '0;
   logic [ARG_W-1:0]      req_first_arg = '0;
   logic [ARG_W-1:0]      req_second_arg = '0;
   logic [ARG_W-1:0]      req_third_arg = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_outcome;
   logic [SLOT_W-1:0]     rsp_entry_index;
   logic [HITS_W-1:0]     rsp_entry_hits;
   logic [PID_W-1:0]      rsp_first_pid;
   logic [INUSE_W-1:0]    rsp_entries_in_use;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   audit_table_mirror table_mirror = new();
   audit_event_type   directed_events[$];
   bit                hold_off_request = 1'b0;
   int                held_cycles = 0;
   int                settings_applied = 0;
   int                cycle_count = 0;

   coalescing_event_audit_table_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_call_number    (req_call_number),
      .req_process_id     (req_process_id),
      .req_first_arg      (req_first_arg),
      .req_second_arg     (req_second_arg),
      .req_third_arg      (req_third_arg),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_entry_hits     (rsp_entry_hits),
      .rsp_first_pid      (rsp_first_pid),
      .rsp_entries_in_use (rsp_entries_in_use),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding",
                  table_mirror.awaited_results.size());
         $display("coalescing_event_audit_table_top regression: fail");
         $finish;
      end
   end

   // Build one directed event word.
   function automatic audit_event_type event_of(logic [CALL_W-1:0] call_num,
                                                logic [PID_W-1:0] pid, logic [ARG_W-1:0] a,
                                                logic [ARG_W-1:0] b, logic [ARG_W-1:0] d);
      audit_event_type ev;
      ev.call_number = call_num;
      ev.process_id  = pid;
      ev.first_arg   = a;
      ev.second_arg  = b;
      ev.third_arg   = d;
      return ev;
   endfunction

   // Random event: half of them repeats of stored keys, plus near misses, exemption
   // candidates and fresh keys, so the table fills gradually and then overflows.
   function automatic audit_event_type next_event();
      audit_event_type ev;
      int              roll;
      int              slot;
      int              bit_pos;
      ev.call_number = CALL_W'($urandom_range(0, 1023));
      ev.process_id  = PID_W'($urandom);
      ev.first_arg   = {$urandom, $urandom};
      ev.second_arg  = {$urandom, $urandom};
      ev.third_arg   = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 62 && table_mirror.fill > 0) begin
         slot = $urandom_range(0, table_mirror.fill - 1);
         ev.call_number = table_mirror.key_call[slot];
         ev.first_arg   = table_mirror.key_a[slot];
         ev.second_arg  = table_mirror.key_b[slot];
         ev.third_arg   = table_mirror.key_c[slot];
         // Near miss: one key bit flipped.
         if (roll >= 50) begin
            case ($urandom_range(0, 3))
               0: begin
                  bit_pos = $urandom_range(0, CALL_W - 1);
                  ev.call_number[bit_pos] = ~ev.call_number[bit_pos];
               end
               1: begin
                  bit_pos = $urandom_range(0, ARG_W - 1);
                  ev.first_arg[bit_pos] = ~ev.first_arg[bit_pos];
               end
               2: begin
                  bit_pos = $urandom_range(0, ARG_W - 1);
                  ev.second_arg[bit_pos] = ~ev.second_arg[bit_pos];
               end
               default: begin
                  bit_pos = $urandom_range(0, ARG_W - 1);
                  ev.third_arg[bit_pos] = ~ev.third_arg[bit_pos];
               end
            endcase
         end
      end else if (roll < 75) begin
         // ioctl on the exempt descriptor; sometimes with bit 31 set so it misses.
         ev.call_number     = table_mirror.ioctl_call;
         ev.first_arg[31:0] = {($urandom_range(0, 3) == 0), table_mirror.exempt_desc};
      end
      return ev;
   endfunction

   // Drive one event word and hold it until the block takes it.
   task automatic send_event(input audit_event_type ev);
      req_valid       <= 1'b1;
      req_call_number <= ev.call_number;
      req_process_id  <= ev.process_id;
      req_first_arg   <= ev.first_arg;
      req_second_arg  <= ev.second_arg;
      req_third_arg   <= ev.third_arg;
      do @(posedge clock); while (req_stall);
      table_mirror.record_event(ev);
   endtask

   // Send a number of words in bursts; directed words go first. During the
   // receiver hold-off the sender keeps offering with no gaps.
   task automatic send_batch(input int count);
      audit_event_type ev;
      int              burst_left;
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         if (directed_events.size() != 0)
            ev = directed_events.pop_front();
         else
            ev = next_event();
         send_event(ev);
         burst_left--;
         if (burst_left <= 0 && !hold_off_request) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
      req_valid <= 1'b0;
   endtask

   // One register write; the caller lowers csr_valid after its last write.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      table_mirror.note_config(idx, data);
   endtask

   // Write all registers with junk in the unused upper bits, plus one write
   // to the unused index.
   task automatic configure(input logic exempt_bit, input logic [DESC_W-1:0] desc,
                            input logic [CALL_W-1:0] call_num);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      csr_write(CSR_EXEMPT_DESC, {junk[31], desc});
      csr_write(CSR_IOCTL_CALL, {junk[31:10], call_num});
      csr_write(CSR_UNUSED_INDEX, $urandom);
      csr_write(CSR_EXEMPT_ENABLE, {junk[31:1], exempt_bit});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Registers change only with the block idle.
   task automatic wait_drained();
      while (table_mirror.awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // Result side: stall patterns change per stretch; one long hold-off on request.
   initial begin : result_sink
      int      stretch;
      int      stall_pct;
      rsp_type got;
      forever begin
         stretch = $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 90;
         endcase
         repeat (stretch) begin
            @(posedge clock);
            if (!reset && rsp_valid && !rsp_stall) begin
               got = {rsp_outcome, rsp_entry_index, rsp_entry_hits, rsp_first_pid,
                      rsp_entries_in_use};
               table_mirror.check_result(got);
            end
            if (hold_off_request) begin
               rsp_stall <= 1'b1;
               held_cycles++;
               if (held_cycles == HOLD_CYCLES)
                  hold_off_request = 1'b0;
            end else begin
               rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
         end
      end
   end

   // Stimulus: directed words across several settings, then random phases.
   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: exemption off, so an ioctl on descriptor 0 is recorded.
      directed_events.push_back(event_of('0, '0, '0, '0, '0));
      directed_events.push_back(event_of('0, '1, '0, '0, '0));
      directed_events.push_back(event_of('1, '1, '1, '1, '1));
      directed_events.push_back(event_of(IOCTL_CALL_RESET, 22'd7, '0, '0, '0));
      send_batch(directed_events.size());

      // Exemption on: upper half of the first argument is ignored, bit 31 is not,
      // and keys differing in one field only are distinct.
      wait_drained();
      configure(1'b1, 31'd5, IOCTL_CALL_RESET);
      directed_events.push_back(event_of(IOCTL_CALL_RESET, 22'd1, 64'hDEAD_BEEF_0000_0005,
                                         64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
      directed_events.push_back(event_of(IOCTL_CALL_RESET, 22'd2, 64'h0000_0000_8000_0005,
                                         '0, '0));
      directed_events.push_back(event_of(IOCTL_CALL_RESET, 22'd3, 64'd6, '0, '0));
      directed_events.push_back(event_of(10'd17, 22'd4, 64'd5, '0, '0));
      directed_events.push_back(event_of('1, 22'd5, '1, '1, ~64'd1));
      directed_events.push_back(event_of('1, 22'd6, '1, 64'h7FFF_FFFF_FFFF_FFFF, '1));
      directed_events.push_back(event_of(10'd1022, 22'd7, '1, '1, '1));
      directed_events.push_back(event_of('0, 22'd9, '0, '0, '0));
      directed_events.push_back(event_of('1, '0, '1, '1, '1));
      send_batch(directed_events.size());

      // Exemption off: the same ioctl is looked up and merged.
      wait_drained();
      configure(1'b0, 31'd5, IOCTL_CALL_RESET);
      directed_events.push_back(event_of(IOCTL_CALL_RESET, 22'd8, 64'd5, '0, '0));
      directed_events.push_back(event_of(IOCTL_CALL_RESET, 22'd8, 64'd5, '0, '0));
      send_batch(directed_events.size());

      // Largest descriptor and call number.
      wait_drained();
      configure(1'b1, '1, '1);
      directed_events.push_back(event_of('1, 22'd1, 64'h0000_0000_7FFF_FFFF, '1, '1));
      directed_events.push_back(event_of('1, 22'd1, '1, '1, '1));
      send_batch(directed_events.size());

      // Smallest descriptor and call number.
      wait_drained();
      configure(1'b1, '0, '0);
      directed_events.push_back(event_of('0, 22'd3, '0, '0, '0));
      directed_events.push_back(event_of('0, 22'd3, 64'h0000_0001_0000_0000, '0, '0));
      directed_events.push_back(event_of(10'd1, 22'd3, '0, '0, '0));
      send_batch(directed_events.size());

      // Random phases, each under its own settings.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: configure(1'b1, DESC_W'($urandom_range(0, 255)), IOCTL_CALL_RESET);
            1: configure(1'b0, DESC_W'($urandom), CALL_W'($urandom));
            2: configure(1'b1, '1, '1);
            3: configure(1'b1, '0, '0);
            default: configure(1'b1, DESC_W'($urandom), CALL_W'($urandom));
         endcase
         // Hold the result side off so the block backs up into its input.
         if (phase == 2)
            hold_off_request = 1'b1;
         send_batch(RANDOM_PER_PHASE);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d events under %0d register settings: %0d new, %0d merged,",
               table_mirror.events_seen, settings_applied,
               table_mirror.outcome_tally[OUT_NEW], table_mirror.outcome_tally[OUT_MERGED]);
      $display("%0d exempt, %0d dropped; %0d of %0d slots used; output held %0d cycles",
               table_mirror.outcome_tally[OUT_EXEMPT], table_mirror.outcome_tally[OUT_DROPPED],
               table_mirror.fill, TABLE_DEPTH, held_cycles);
      if (table_mirror.errors == 0 && table_mirror.awaited_results.size() == 0)
         $display("coalescing_event_audit_table_top regression: pass");
      else
         $display("coalescing_event_audit_table_top regression: fail");
      $finish;
   end

endmodule
